@@ src/bfr_pkg.sv @@
// Byte frequency ranker: shared types, widths and codes.
// No dependencies; compiled first.
package bfr_pkg;

    localparam int SYM_W     = 8;
    localparam int ORDER_W   = 8;
    localparam int RANK_W    = 8;
    localparam int DIST_W    = 9;
    localparam int OUT_CNT_W = 16;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOK,
        ST_DECIDE,
        ST_MOVE,
        ST_GATHER,
        ST_RESULT
    } state_t;

    typedef enum logic [2:0] {
        OP_HOLD,
        OP_LOOK,
        OP_INC,
        OP_INS,
        OP_STEP
    } cell_op_t;

    // Broadcast to every cell
    typedef struct packed {
        cell_op_t             op;
        logic [SYM_W-1:0]     byte_val;
        logic [RANK_W-1:0]    rank;
        logic [DIST_W-1:0]    distinct;
        logic [ORDER_W-1:0]   new_order;
    } cell_ctrl_t;

    // What a cell shows its neighbours
    typedef struct packed {
        logic [SYM_W-1:0]     symbol;
        logic [ORDER_W-1:0]   order;
        logic                 valid;
        logic                 cnt_one;
        logic                 swap;
    } cell_link_t;

endpackage

@@ src/bfr_in_if.sv @@
// Byte frequency ranker: command channel (cmd, data_byte, rank).
// Depends on bfr_pkg.
interface bfr_in_if;
    import bfr_pkg::*;

    logic               valid;
    logic               ready;
    logic               cmd;
    logic [SYM_W-1:0]   data_byte;
    logic [RANK_W-1:0]  rank;

    modport source (output valid, output cmd, output data_byte, output rank, input ready);
    modport sink   (input valid, input cmd, input data_byte, input rank, output ready);
endinterface

@@ src/bfr_out_if.sv @@
// Byte frequency ranker: result channel (symbol, count, distinct, rank_valid).
// Depends on bfr_pkg.
interface bfr_out_if;
    import bfr_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [SYM_W-1:0]      symbol;
    logic [OUT_CNT_W-1:0]  count;
    logic [DIST_W-1:0]     distinct;
    logic                  rank_valid;

    modport source (output valid, output symbol, output count, output distinct,
                    output rank_valid, input ready);
    modport sink   (input valid, input symbol, input count, input distinct,
                    input rank_valid, output ready);
endinterface

@@ src/bfr_cell.sv @@
// Byte frequency ranker: one cell of the ranking chain (one rank position).
// Depends on bfr_pkg.
module bfr_cell #(
    parameter int INDEX       = 0,
    parameter int COUNT_WIDTH = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  bfr_pkg::cell_ctrl_t         ctrl,
    input  bfr_pkg::cell_link_t         left,
    input  logic [COUNT_WIDTH-1:0]      left_count,
    input  bfr_pkg::cell_link_t         right,
    input  logic [COUNT_WIDTH-1:0]      right_count,
    output bfr_pkg::cell_link_t         link,
    output logic [COUNT_WIDTH-1:0]      link_count,
    output logic                        match,
    output logic                        moving,
    output logic [bfr_pkg::SYM_W-1:0]   rd_symbol,
    output logic [COUNT_WIDTH-1:0]      rd_count
);
    import bfr_pkg::*;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
    localparam logic [DIST_W-1:0]      MY_POS    = DIST_W'(INDEX);
    localparam logic [RANK_W-1:0]      MY_RANK   = RANK_W'(INDEX);

    logic [SYM_W-1:0]       symbol_reg, symbol_next;
    logic [COUNT_WIDTH-1:0] count_reg,  count_next;
    logic [ORDER_W-1:0]     order_reg,  order_next;
    logic                   moving_reg, moving_next;
    logic                   match_reg,  match_next;

    logic valid, cnt_one, before_right, swap_out, ins_point, shift_in;

    always_comb
    begin
        valid   = MY_POS < ctrl.distinct;
        cnt_one = valid && (count_reg == COUNT_WIDTH'(1));
        // right neighbour ranks before this entry
        before_right = right.valid &&
                       ((right_count < count_reg) ||
                        ((right_count == count_reg) && (right.order < order_reg)));
        swap_out  = (ctrl.op == OP_STEP) && moving_reg && before_right;
        // new symbol lands after the run of count-one entries
        ins_point = ((INDEX == 0) || (left.valid && left.cnt_one)) && !cnt_one;
        shift_in  = left.valid && !left.cnt_one;
    end

    always_comb
    begin
        symbol_next = symbol_reg;
        count_next  = count_reg;
        order_next  = order_reg;
        moving_next = moving_reg;
        match_next  = match_reg;
        case (ctrl.op)
            OP_LOOK:
            begin
                match_next = valid && (symbol_reg == ctrl.byte_val);
            end
            OP_INC:
            begin
                if (match_reg && (count_reg != COUNT_MAX))
                begin
                    count_next  = count_reg + COUNT_WIDTH'(1);
                    moving_next = 1'b1;
                end
            end
            OP_INS:
            begin
                if (ins_point)
                begin
                    symbol_next = ctrl.byte_val;
                    count_next  = COUNT_WIDTH'(1);
                    order_next  = ctrl.new_order;
                end
                else if (shift_in)
                begin
                    symbol_next = left.symbol;
                    count_next  = left_count;
                    order_next  = left.order;
                end
            end
            OP_STEP:
            begin
                if (swap_out)
                begin
                    symbol_next = right.symbol;
                    count_next  = right_count;
                    order_next  = right.order;
                    moving_next = 1'b0;
                end
                else if (left.swap)
                begin
                    symbol_next = left.symbol;
                    count_next  = left_count;
                    order_next  = left.order;
                    moving_next = 1'b1;
                end
                else
                begin
                    moving_next = 1'b0;
                end
            end
            default:
            begin
                moving_next = moving_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            moving_reg <= 1'b0;
            match_reg  <= 1'b0;
        end
        else
        begin
            moving_reg <= moving_next;
            match_reg  <= match_next;
        end
    end

    always_ff @(posedge clk)
    begin
        symbol_reg <= symbol_next;
        count_reg  <= count_next;
        order_reg  <= order_next;
    end

    logic rd_sel;

    always_comb
    begin
        link.symbol = symbol_reg;
        link.order  = order_reg;
        link.valid  = valid;
        link.cnt_one = cnt_one;
        link.swap   = swap_out;
        link_count  = count_reg;
        match       = match_reg;
        moving      = moving_reg;
        rd_sel      = valid && (ctrl.rank == MY_RANK);
        rd_symbol   = rd_sel ? symbol_reg : '0;
        rd_count    = rd_sel ? count_reg  : '0;
    end

endmodule

@@ src/byte_frequency_ranker_unit.sv @@
// Byte frequency ranker, top level: controller, cell chain and read-out tree.
// Depends on bfr_pkg, bfr_in_if, bfr_out_if and bfr_cell.
//
// Counts byte values and keeps the distinct symbols in ascending order of
// count, ties broken by first appearance. Each rank position is one cell;
// cells compare against a broadcast byte and trade entries only with their
// neighbours. One item is worked on at a time. A count of a new symbol does
// a look-up, then an insert that shifts the chain. A count of a known symbol
// does a look-up and an increment, then the entry climbs: the chain swaps one
// neighbour pair per cycle, then finds no further swap and then sees the
// chain at rest. A count at saturation, and a new symbol arriving when the
// store already holds SYMBOL_COUNT symbols, change nothing. A read selects
// the rank, takes a registered OR over groups of 16 cells, then a final OR
// into the result register, and waits in its last step only while an earlier
// result has not been transferred. Reads of a rank at or beyond the number of
// distinct symbols return zero symbol and count with rank_valid low. No
// clearing pass is needed after reset: the distinct counter masks the store.
module byte_frequency_ranker_unit #(
    parameter int COUNT_WIDTH  = 16,
    parameter int SYMBOL_COUNT = 256
) (
    input logic      clk,
    input logic      rst_n,
    bfr_in_if.sink   req,
    bfr_out_if.source rsp
);
    import bfr_pkg::*;

    localparam int GRP  = 16;
    localparam int NGRP = (SYMBOL_COUNT + GRP - 1) / GRP;
    localparam logic [DIST_W-1:0] LIMIT = DIST_W'(SYMBOL_COUNT);

    // ---------------- control registers ----------------
    state_t              state_reg, state_next;
    logic [SYM_W-1:0]    byte_reg,  byte_next;
    logic [RANK_W-1:0]   rank_reg,  rank_next;
    logic [DIST_W-1:0]   distinct_reg, distinct_next;

    // result register
    logic                  out_valid_reg, out_valid_next;
    logic [SYM_W-1:0]      out_sym_reg,   out_sym_next;
    logic [OUT_CNT_W-1:0]  out_cnt_reg,   out_cnt_next;
    logic [DIST_W-1:0]     out_dist_reg,  out_dist_next;
    logic                  out_rv_reg,    out_rv_next;

    // ---------------- cell chain ----------------
    cell_ctrl_t              ctrl;
    cell_link_t              link      [SYMBOL_COUNT];
    logic [COUNT_WIDTH-1:0]  link_count[SYMBOL_COUNT];
    logic [SYMBOL_COUNT-1:0] match_vec;
    logic [SYMBOL_COUNT-1:0] moving_vec;
    logic [SYM_W-1:0]        rd_sym[NGRP*GRP];
    logic [COUNT_WIDTH-1:0]  rd_cnt[NGRP*GRP];

    localparam cell_link_t LINK_NONE = '0;

    logic found, busy, accept, out_transfer;

    assign found        = |match_vec;
    assign busy         = |moving_vec;
    assign accept       = req.valid && req.ready;
    assign out_transfer = out_valid_reg && rsp.ready;

    for (genvar i = 0; i < SYMBOL_COUNT; i++)
    begin : g_cell
        cell_link_t             left_l, right_l;
        logic [COUNT_WIDTH-1:0] left_c, right_c;

        if (i == 0)
        begin : g_first
            assign left_l = LINK_NONE;
            assign left_c = '0;
        end
        else
        begin : g_mid_l
            assign left_l = link[i-1];
            assign left_c = link_count[i-1];
        end

        if (i == SYMBOL_COUNT - 1)
        begin : g_last
            assign right_l = LINK_NONE;
            assign right_c = '0;
        end
        else
        begin : g_mid_r
            assign right_l = link[i+1];
            assign right_c = link_count[i+1];
        end

        bfr_cell #(
            .INDEX       (i),
            .COUNT_WIDTH (COUNT_WIDTH)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl),
            .left        (left_l),
            .left_count  (left_c),
            .right       (right_l),
            .right_count (right_c),
            .link        (link[i]),
            .link_count  (link_count[i]),
            .match       (match_vec[i]),
            .moving      (moving_vec[i]),
            .rd_symbol   (rd_sym[i]),
            .rd_count    (rd_cnt[i])
        );
    end

    // pad the read-out tree to whole groups
    for (genvar p = SYMBOL_COUNT; p < NGRP*GRP; p++)
    begin : g_pad
        assign rd_sym[p] = '0;
        assign rd_cnt[p] = '0;
    end

    // ---------------- read-out tree, first level registered ----------------
    logic [SYM_W-1:0]       grp_sym_reg[NGRP];
    logic [COUNT_WIDTH-1:0] grp_cnt_reg[NGRP];
    logic [SYM_W-1:0]       grp_sym_next[NGRP];
    logic [COUNT_WIDTH-1:0] grp_cnt_next[NGRP];

    for (genvar g = 0; g < NGRP; g++)
    begin : g_grp
        always_comb
        begin
            grp_sym_next[g] = '0;
            grp_cnt_next[g] = '0;
            for (int j = 0; j < GRP; j++)
            begin
                grp_sym_next[g] = grp_sym_next[g] | rd_sym[g*GRP + j];
                grp_cnt_next[g] = grp_cnt_next[g] | rd_cnt[g*GRP + j];
            end
        end

        always_ff @(posedge clk)
        begin
            if (state_reg == ST_GATHER)
            begin
                grp_sym_reg[g] <= grp_sym_next[g];
                grp_cnt_reg[g] <= grp_cnt_next[g];
            end
        end
    end

    logic [SYM_W-1:0]       tree_sym;
    logic [COUNT_WIDTH-1:0] tree_cnt;

    always_comb
    begin
        tree_sym = '0;
        tree_cnt = '0;
        for (int g = 0; g < NGRP; g++)
        begin
            tree_sym = tree_sym | grp_sym_reg[g];
            tree_cnt = tree_cnt | grp_cnt_reg[g];
        end
    end

    // ---------------- next state ----------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = req.cmd ? ST_GATHER : ST_LOOK;
            end
            ST_LOOK:   state_next = ST_DECIDE;
            ST_DECIDE: state_next = found ? ST_MOVE : ST_IDLE;
            ST_MOVE:
            begin
                if (!busy)
                    state_next = ST_IDLE;
            end
            ST_GATHER: state_next = ST_RESULT;
            ST_RESULT:
            begin
                if (!out_valid_reg || rsp.ready)
                    state_next = ST_IDLE;
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // ---------------- outputs of the controller ----------------
    always_comb
    begin
        ctrl.op        = OP_HOLD;
        ctrl.byte_val  = byte_reg;
        ctrl.rank      = rank_reg;
        ctrl.distinct  = distinct_reg;
        ctrl.new_order = ORDER_W'(distinct_reg);
        distinct_next  = distinct_reg;
        byte_next      = byte_reg;
        rank_next      = rank_reg;
        out_valid_next = out_transfer ? 1'b0 : out_valid_reg;
        out_sym_next   = out_sym_reg;
        out_cnt_next   = out_cnt_reg;
        out_dist_next  = out_dist_reg;
        out_rv_next    = out_rv_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    byte_next = req.data_byte;
                    rank_next = req.rank;
                end
            end
            ST_LOOK:
            begin
                ctrl.op = OP_LOOK;
            end
            ST_DECIDE:
            begin
                if (found)
                    ctrl.op = OP_INC;
                else if (distinct_reg < LIMIT)
                begin
                    ctrl.op       = OP_INS;
                    distinct_next = distinct_reg + DIST_W'(1);
                end
            end
            ST_MOVE:
            begin
                if (busy)
                    ctrl.op = OP_STEP;
            end
            ST_RESULT:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_sym_next   = tree_sym;
                    out_cnt_next   = OUT_CNT_W'(tree_cnt);
                    out_dist_next  = distinct_reg;
                    out_rv_next    = {1'b0, rank_reg} < distinct_reg;
                end
            end
            default:
            begin
                ctrl.op = OP_HOLD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            distinct_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            distinct_reg  <= distinct_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg     <= byte_next;
        rank_reg     <= rank_next;
        out_sym_reg  <= out_sym_next;
        out_cnt_reg  <= out_cnt_next;
        out_dist_reg <= out_dist_next;
        out_rv_reg   <= out_rv_next;
    end

    assign req.ready      = (state_reg == ST_IDLE);
    assign rsp.valid      = out_valid_reg;
    assign rsp.symbol     = out_sym_reg;
    assign rsp.count      = out_cnt_reg;
    assign rsp.distinct   = out_dist_reg;
    assign rsp.rank_valid = out_rv_reg;

endmodule

@@ src/bfr_checker.sv @@
// Byte frequency ranker: port-level checks, bound to the top level.
// Depends on bfr_pkg and byte_frequency_ranker_unit.
module bfr_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          req_valid,
    input logic                          req_ready,
    input logic                          req_cmd,
    input logic                          rsp_valid,
    input logic                          rsp_ready,
    input logic [bfr_pkg::SYM_W-1:0]     rsp_symbol,
    input logic [bfr_pkg::OUT_CNT_W-1:0] rsp_count,
    input logic [bfr_pkg::DIST_W-1:0]    rsp_distinct,
    input logic                          rsp_rank_valid
);
    import bfr_pkg::*;

    // result held until transferred
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result dropped before transfer");

    // one item in flight: ready drops after each accepted item
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("item accepted while busy");

    // out-of-range rank reads as zero
    a_empty_rank: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_rank_valid |-> rsp_symbol == '0 && rsp_count == '0)
        else $error("invalid rank carries data");

    // a valid rank implies a non-empty store
    a_rank_store: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_rank_valid |-> rsp_distinct != '0)
        else $error("valid rank with empty store");

    // a fresh result is preceded by an accepted read command
    a_read_lat: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(req_valid && req_ready && req_cmd, 3))
        else $error("result without read command");

endmodule

bind byte_frequency_ranker_unit bfr_checker u_bfr_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req.valid),
    .req_ready      (req.ready),
    .req_cmd        (req.cmd),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_symbol     (rsp.symbol),
    .rsp_count      (rsp.count),
    .rsp_distinct   (rsp.distinct),
    .rsp_rank_valid (rsp.rank_valid)
);

@@ tb/bfr_checker.sv @@
// Scoreboard for the byte frequency ranker: watches both channels, keeps its
// own ranked histogram and compares every read reply with the expected one.
// Depends on bfr_pkg, bfr_in_if and bfr_out_if.
module bfr_scoreboard #(
    parameter int   COUNT_WIDTH  = 16,
    parameter int   SYMBOL_COUNT = 256,
    parameter logic READ_OP      = 1'b1
) (
    input  logic clk,
    input  logic rst_n,
    bfr_in_if    req,
    bfr_out_if   rsp,
    output int   faults,
    output int   replies_owed
);
    timeunit 1ns;
    timeprecision 1ps;

    import bfr_pkg::*;

    localparam int SLOTS = 256;
    localparam logic [COUNT_WIDTH-1:0] COUNT_CEIL = '1;

    typedef struct packed {
        logic [SYM_W-1:0]     symbol;
        logic [OUT_CNT_W-1:0] count;
        logic [DIST_W-1:0]    distinct;
        logic                 rank_valid;
    } rank_reply_t;

    // Ranked store: ascending count, ties by arrival
    logic [SYM_W-1:0]       slot_sym [SLOTS];
    logic [COUNT_WIDTH-1:0] slot_cnt [SLOTS];
    logic [ORDER_W-1:0]     slot_age [SLOTS];
    int                     n_symbols;
    rank_reply_t            replies_due [$];
    int                     fault_tally = 0;

    function automatic void tally_byte(input logic [SYM_W-1:0] b);
        int                     p;
        int                     ins;
        logic [SYM_W-1:0]       t_sym;
        logic [COUNT_WIDTH-1:0] t_cnt;
        logic [ORDER_W-1:0]     t_age;
        p = 0;
        while (p < n_symbols && slot_sym[p] != b)
            p++;
        if (p < n_symbols) begin
            if (slot_cnt[p] == COUNT_CEIL)
                return;
            slot_cnt[p] = slot_cnt[p] + 1'b1;
            // climb past neighbours that now rank below it
            while (p + 1 < n_symbols &&
                   (slot_cnt[p+1] < slot_cnt[p] ||
                    (slot_cnt[p+1] == slot_cnt[p] && slot_age[p+1] < slot_age[p])))
            begin
                t_sym         = slot_sym[p];
                t_cnt         = slot_cnt[p];
                t_age         = slot_age[p];
                slot_sym[p]   = slot_sym[p+1];
                slot_cnt[p]   = slot_cnt[p+1];
                slot_age[p]   = slot_age[p+1];
                slot_sym[p+1] = t_sym;
                slot_cnt[p+1] = t_cnt;
                slot_age[p+1] = t_age;
                p++;
            end
        end
        else if (n_symbols < SYMBOL_COUNT && n_symbols < SLOTS) begin
            // newcomer goes after every count-1 entry
            ins = 0;
            while (ins < n_symbols && slot_cnt[ins] <= 1)
                ins++;
            for (int k = n_symbols; k > ins; k--) begin
                slot_sym[k] = slot_sym[k-1];
                slot_cnt[k] = slot_cnt[k-1];
                slot_age[k] = slot_age[k-1];
            end
            slot_sym[ins] = b;
            slot_cnt[ins] = 1;
            slot_age[ins] = ORDER_W'(n_symbols);
            n_symbols++;
        end
    endfunction

    function automatic void match_field(input string field, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
            fault_tally++;
        end
    endfunction

    always @(posedge clk or negedge rst_n) begin
        rank_reply_t want;
        if (!rst_n) begin
            n_symbols = 0;
            replies_due.delete();
            replies_owed <= 0;
        end
        else begin
            if (rsp.valid && rsp.ready) begin
                if (replies_due.size() == 0) begin
                    $error("reply with none due: symbol 0x%0h count %0d",
                           rsp.symbol, rsp.count);
                    fault_tally++;
                end
                else begin
                    want = replies_due.pop_front();
                    match_field("symbol", 32'(want.symbol), 32'(rsp.symbol));
                    match_field("count", 32'(want.count), 32'(rsp.count));
                    match_field("distinct", 32'(want.distinct), 32'(rsp.distinct));
                    match_field("rank_valid", 32'(want.rank_valid), 32'(rsp.rank_valid));
                end
            end
            if (req.valid && req.ready) begin
                if (req.cmd == READ_OP) begin
                    want          = '0;
                    want.distinct = DIST_W'(n_symbols);
                    if (int'(req.rank) < n_symbols) begin
                        want.symbol     = slot_sym[req.rank];
                        want.count      = OUT_CNT_W'(slot_cnt[req.rank]);
                        want.rank_valid = 1'b1;
                    end
                    replies_due = {replies_due, want};
                end
                else
                    tally_byte(req.data_byte);
            end
            replies_owed <= replies_due.size();
            faults       <= fault_tally;
        end
    end

endmodule

@@ tb/tb_byte_frequency_ranker_unit.sv @@
// Testbench top for byte_frequency_ranker_unit: clock, reset, command
// stimulus, reply back-pressure, watchdog and verdict.
// Depends on bfr_pkg, bfr_in_if, bfr_out_if, the block and bfr_scoreboard.
module tb_byte_frequency_ranker_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import bfr_pkg::*;

    localparam int   COUNT_WIDTH  = 16;
    localparam int   SYMBOL_COUNT = 256;
    localparam logic CMD_COUNT    = 1'b0;
    localparam logic CMD_READ     = 1'b1;
    localparam int   HALF_PERIOD  = 6;
    localparam int   RESET_CYCLES = 12;
    // Hold-off on the reply side; long enough to stall a read and back up the
    // command channel behind it.
    localparam int   HOLD_OFF     = 300;
    // Longest legal stretch with no transfer on either side: the hold-off,
    // plus a full climb of 255 places, plus stall tails. Taken many times over.
    localparam int   STALL_LIMIT  = 5000;
    // Settling time after the last reply.
    localparam int   DRAIN_CYCLES = 20;
    // Counts of one byte in a row, enough to lift it to the top rank
    localparam int   HEAVY_N      = 30;

    logic clk = 1'b0;
    logic rst_n;

    bfr_in_if  req_ch ();
    bfr_out_if rsp_ch ();

    int faults;
    int replies_owed;

    // Idle chances in percent, per cycle; changed between phases
    int src_idle_pct = 12;
    int snk_idle_pct = 79;
    int hold_left    = 0;

    // Distinct bytes counted so far, to aim most reads inside the valid range
    bit               seen [256];
    int               n_seen = 0;
    // A few frequently counted symbols so that counts grow, tie and climb
    logic [SYM_W-1:0] hot [4];

    always #(HALF_PERIOD) clk = ~clk;

    byte_frequency_ranker_unit #(
        .COUNT_WIDTH  (COUNT_WIDTH),
        .SYMBOL_COUNT (SYMBOL_COUNT)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    bfr_scoreboard #(
        .COUNT_WIDTH  (COUNT_WIDTH),
        .SYMBOL_COUNT (SYMBOL_COUNT),
        .READ_OP      (CMD_READ)
    ) u_chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .req          (req_ch),
        .rsp          (rsp_ch),
        .faults       (faults),
        .replies_owed (replies_owed)
    );

    // Reply side: random stalls, or a solid hold-off when one is requested.
    initial begin
        rsp_ch.ready = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_left > 0) begin
                rsp_ch.ready <= 1'b0;
                hold_left--;
            end
            else
                rsp_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // Watchdog: ends the run if neither channel makes a transfer for too long.
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    // Offers one command and returns at the edge of its transfer. Valid stays
    // high afterwards, so back-to-back commands need no extra edge; a random
    // gap lowers it first.
    task automatic offer(input logic op, input logic [SYM_W-1:0] b,
                         input logic [RANK_W-1:0] r);
        while ($urandom_range(99) < src_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.cmd       <= op;
        req_ch.data_byte <= b;
        req_ch.rank      <= r;
        do
            @(posedge clk);
        while (!req_ch.ready);
        if (op == CMD_COUNT && !seen[b]) begin
            seen[b] = 1'b1;
            n_seen++;
        end
    endtask

    // Unused fields carry random values throughout
    task automatic tally_in(input logic [SYM_W-1:0] b);
        offer(CMD_COUNT, b, RANK_W'($urandom));
    endtask

    task automatic ask_rank(input logic [RANK_W-1:0] r);
        offer(CMD_READ, SYM_W'($urandom), r);
    endtask

    // Mostly a rank in range; now and then anywhere, including beyond it
    function automatic logic [RANK_W-1:0] pick_rank();
        if (n_seen == 0 || $urandom_range(9) < 2)
            return RANK_W'($urandom);
        return RANK_W'($urandom_range(n_seen - 1));
    endfunction

    // Drops valid and waits until every reply due has been transferred.
    // The first edge lets the checker's count catch up with the last transfer.
    task automatic drain_replies();
        req_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (replies_owed != 0);
    endtask

    // Random traffic: bursts of counts on hot or random bytes, single reads,
    // short sweeps of neighbouring ranks, and some fully random commands.
    task automatic mixed_traffic(input int n_items);
        int sent;
        int kind;
        int len;
        int first;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(31) == 0)
                hot[$urandom_range(3)] = SYM_W'($urandom);
            kind = $urandom_range(99);
            if (kind < 45) begin
                len = $urandom_range(1, 8);
                repeat (len)
                    tally_in(($urandom_range(3) != 0) ? hot[$urandom_range(3)]
                                                      : SYM_W'($urandom));
                sent += len;
            end
            else if (kind < 80) begin
                ask_rank(pick_rank());
                sent++;
            end
            else if (kind < 90) begin
                len   = $urandom_range(2, 8);
                first = pick_rank();
                for (int k = 0; k < len; k++)
                    ask_rank(RANK_W'(first + k));
                sent += len;
            end
            else begin
                offer(logic'($urandom_range(1)), SYM_W'($urandom), RANK_W'($urandom));
                sent++;
            end
        end
    endtask

    initial begin
        logic [SYM_W-1:0] perm [256];
        logic [SYM_W-1:0] t;
        int               j;

        rst_n            = 1'b0;
        req_ch.valid     = 1'b0;
        req_ch.cmd       = CMD_COUNT;
        req_ch.data_byte = '0;
        req_ch.rank      = '0;
        foreach (hot[i])
            hot[i] = SYM_W'($urandom);
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // ---- Phase 1: sender seldom idle, receiver mostly stalled ----

        // Reads on an empty store: out of range at both ends
        ask_rank('0);
        ask_rank('1);
        // Zero byte and all-ones byte enter with count 1, in arrival order
        tally_in(8'h00);
        tally_in(8'hFF);
        // Zero byte climbs past 0xFF
        tally_in(8'h00);
        tally_in(8'hA5);
        tally_in(8'h5A);
        // 0xFF ties with the zero byte at 2; earlier arrival ranks first
        tally_in(8'hFF);
        for (int r = 0; r < 4; r++)
            ask_rank(RANK_W'(r));
        // Rank equal to distinct, and far beyond it
        ask_rank(RANK_W'(4));
        ask_rank('1);
        // Newcomer lands after the count-1 entries but before larger counts
        tally_in(8'h3C);
        ask_rank(RANK_W'(2));
        ask_rank(RANK_W'(4));

        mixed_traffic(550);

        // ---- Back-pressure: replies held off while commands keep coming ----
        hold_left = HOLD_OFF;
        repeat (6) begin
            ask_rank(pick_rank());
            tally_in(hot[0]);
        end
        // Sender pauses until every reply has been transferred
        drain_replies();

        // ---- Phase 2: sender mostly idle, receiver seldom stalled ----
        src_idle_pct = 79;
        snk_idle_pct = 12;

        // Every byte value once, in shuffled order: fills the store to 256
        foreach (perm[i])
            perm[i] = SYM_W'(i);
        for (int i = 255; i > 0; i--) begin
            j       = $urandom_range(i);
            t       = perm[i];
            perm[i] = perm[j];
            perm[j] = t;
        end
        foreach (perm[i])
            tally_in(perm[i]);

        mixed_traffic(500);

        // ---- Phase 3: no idling on either side ----
        src_idle_pct = 0;
        snk_idle_pct = 0;

        // Whole ranking, top rank included with a full store
        for (int r = 0; r < 256; r++)
            ask_rank(RANK_W'(r));

        mixed_traffic(300);

        // Heavy symbol: long climbs through a full store, then read at the top
        t = hot[1];
        repeat (HEAVY_N)
            tally_in(t);
        ask_rank('1);
        tally_in(t);
        for (int r = 250; r < 256; r++)
            ask_rank(RANK_W'(r));
        mixed_traffic(20);

        drain_replies();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (faults == 0 && replies_owed == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

@@ files.f @@
src/bfr_pkg.sv
src/bfr_in_if.sv
src/bfr_out_if.sv
src/bfr_cell.sv
src/byte_frequency_ranker_unit.sv
src/bfr_checker.sv
tb/bfr_checker.sv
tb/tb_byte_frequency_ranker_unit.sv
